// File: src/kbest_pkg.sv
package kbest_pkg;

    // request codes
    localparam logic [2:0] REQ_PRESS   = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_TICK    = 3'd2;
    localparam logic [2:0] REQ_QUERY   = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // entry phases
    localparam logic [2:0] PH_INVALID      = 3'd0;
    localparam logic [2:0] PH_REGISTERED   = 3'd1;
    localparam logic [2:0] PH_TRIGGERED    = 3'd2;
    localparam logic [2:0] PH_PRESSED      = 3'd3;
    localparam logic [2:0] PH_UNREGISTERED = 3'd4;
    localparam logic [2:0] PH_RELEASED     = 3'd5;

    localparam int CODE_W  = 32;
    localparam int POS_W   = 16;
    localparam int DELTA_W = 17;

    // request into the entry table
    typedef struct packed {
        logic              fire;
        logic [2:0]        req;
        logic              kind;
        logic [CODE_W-1:0] code;
    } tbl_req_t;

    // answer from the entry table
    typedef struct packed {
        logic [2:0] state;
        logic       full;
    } tbl_rsp_t;

endpackage

// File: src/kbest_table.sv
module kbest_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kbest_pkg::tbl_req_t req,
    output kbest_pkg::tbl_rsp_t rsp
);

    logic [TABLE_DEPTH-1:0]       valid_reg;
    logic [TABLE_DEPTH-1:0]       valid_next;
    logic [TABLE_DEPTH-1:0]       kind_reg;
    logic [kbest_pkg::CODE_W-1:0] code_reg  [TABLE_DEPTH];
    logic [2:0]                   phase_reg [TABLE_DEPTH];
    logic [2:0]                   phase_next[TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       load;
    logic [TABLE_DEPTH-1:0]       hit;
    logic [TABLE_DEPTH-1:0]       free_vec;
    logic [TABLE_DEPTH-1:0]       free_low;
    logic                         any_hit;
    logic                         any_free;
    logic [2:0]                   hit_phase;

    // parallel match against every valid entry, at most one can hit
    always_comb
    begin
        hit_phase = kbest_pkg::PH_INVALID;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit[i]    = valid_reg[i] && (kind_reg[i] == req.kind) && (code_reg[i] == req.code);
            hit_phase = hit_phase | ({3{hit[i]}} & phase_reg[i]);
        end
    end

    assign any_hit  = |hit;

    // lowest free slot as a one-hot vector
    assign free_vec = ~valid_reg;
    assign free_low = free_vec & (~free_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
    assign any_free = |free_vec;

    // response for the current beat
    always_comb
    begin
        rsp.state = kbest_pkg::PH_INVALID;
        rsp.full  = 1'b0;
        case (req.req)
            kbest_pkg::REQ_PRESS:
            begin
                if (any_hit)
                    rsp.state = hit_phase;
                else if (any_free)
                    rsp.state = kbest_pkg::PH_REGISTERED;
                else
                    rsp.full = 1'b1;
            end
            kbest_pkg::REQ_RELEASE:
            begin
                if (any_hit)
                    rsp.state = kbest_pkg::PH_UNREGISTERED;
            end
            kbest_pkg::REQ_QUERY:
            begin
                if (any_hit)
                    rsp.state = hit_phase;
            end
            default:
            begin
            end
        endcase
    end

    // per-entry next state
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            valid_next[i] = valid_reg[i];
            phase_next[i] = phase_reg[i];
            load[i]       = 1'b0;
            if (req.fire)
            begin
                case (req.req)
                    kbest_pkg::REQ_PRESS:
                    begin
                        if (!any_hit && free_low[i])
                        begin
                            valid_next[i] = 1'b1;
                            phase_next[i] = kbest_pkg::PH_REGISTERED;
                            load[i]       = 1'b1;
                        end
                    end
                    kbest_pkg::REQ_RELEASE:
                    begin
                        if (hit[i])
                            phase_next[i] = kbest_pkg::PH_UNREGISTERED;
                    end
                    kbest_pkg::REQ_TICK:
                    begin
                        if (valid_reg[i])
                        begin
                            case (phase_reg[i])
                                kbest_pkg::PH_RELEASED:     valid_next[i] = 1'b0;
                                kbest_pkg::PH_REGISTERED:   phase_next[i] = kbest_pkg::PH_TRIGGERED;
                                kbest_pkg::PH_TRIGGERED:    phase_next[i] = kbest_pkg::PH_PRESSED;
                                kbest_pkg::PH_UNREGISTERED: phase_next[i] = kbest_pkg::PH_RELEASED;
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    kbest_pkg::REQ_CLEAR:
                    begin
                        valid_next[i] = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // entry payload, only read while valid
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            phase_reg[i] <= phase_next[i];
            if (load[i])
            begin
                kind_reg[i] <= req.kind;
                code_reg[i] <= req.code;
            end
        end
    end

endmodule

// File: src/kbest_cursor.sv
module kbest_cursor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick,
    input  logic signed [kbest_pkg::POS_W-1:0]  cursor_x,
    input  logic signed [kbest_pkg::POS_W-1:0]  cursor_y,
    output logic signed [kbest_pkg::DELTA_W-1:0] delta_x_next,
    output logic signed [kbest_pkg::DELTA_W-1:0] delta_y_next
);

    logic signed [kbest_pkg::POS_W-1:0]   now_x_reg;
    logic signed [kbest_pkg::POS_W-1:0]   now_y_reg;
    logic signed [kbest_pkg::DELTA_W-1:0] dx_reg;
    logic signed [kbest_pkg::DELTA_W-1:0] dy_reg;
    logic signed [kbest_pkg::DELTA_W-1:0] dx_calc;
    logic signed [kbest_pkg::DELTA_W-1:0] dy_calc;

    // sign-extended difference against the previous sample
    assign dx_calc = {cursor_x[kbest_pkg::POS_W-1], cursor_x}
                   - {now_x_reg[kbest_pkg::POS_W-1], now_x_reg};
    assign dy_calc = {cursor_y[kbest_pkg::POS_W-1], cursor_y}
                   - {now_y_reg[kbest_pkg::POS_W-1], now_y_reg};

    assign delta_x_next = tick ? dx_calc : dx_reg;
    assign delta_y_next = tick ? dy_calc : dy_reg;

    // cursor sample and latest delta
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_x_reg <= '0;
            now_y_reg <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
        end
        else if (tick)
        begin
            now_x_reg <= cursor_x;
            now_y_reg <= cursor_y;
            dx_reg    <= dx_calc;
            dy_reg    <= dy_calc;
        end
    end

endmodule

// File: src/key_button_edge_state_table_unit.sv
// Key and mouse-button edge state table.
// Input channel (in_valid/in_ready) carries one request per beat: press,
// release, tick, query or clear, with kind bit, code and cursor position.
// Output channel (out_valid/out_ready) returns one result beat per request:
// the entry's phase, the latest cursor delta and the press-dropped flag.
// A request goes through the input register, then the table lookup and
// update into the result register. Throughput is one request per cycle
// while the receiver does not stall; the entry table is a row of registers
// with parallel compares, so every request finishes in one pass.
// When the receiver stalls, one more request is taken into the input
// register while the result waits, then in_ready drops until the result
// beat is taken.
// Reset empties the table, zeroes the cursor sample and the delta, and
// clears both valid flags; no clearing pass is needed.
module key_button_edge_state_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic                is_button,
    input  logic [31:0]         input_code,
    input  logic signed [15:0]  cursor_x,
    input  logic signed [15:0]  cursor_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          entry_state,
    output logic signed [16:0]  delta_x,
    output logic signed [16:0]  delta_y,
    output logic                table_full
);

    logic                                  s1_valid_reg;
    logic [2:0]                            req_reg;
    logic                                  kind_reg;
    logic [kbest_pkg::CODE_W-1:0]          code_reg;
    logic signed [kbest_pkg::POS_W-1:0]    cx_reg;
    logic signed [kbest_pkg::POS_W-1:0]    cy_reg;
    logic                                  out_valid_reg;
    logic [2:0]                            state_reg;
    logic signed [kbest_pkg::DELTA_W-1:0]  dx_reg;
    logic signed [kbest_pkg::DELTA_W-1:0]  dy_reg;
    logic                                  full_reg;
    logic                                  s1_advance;
    logic                                  in_take;
    kbest_pkg::tbl_req_t                   tbl_req;
    kbest_pkg::tbl_rsp_t                   tbl_rsp;
    logic signed [kbest_pkg::DELTA_W-1:0]  dx_next;
    logic signed [kbest_pkg::DELTA_W-1:0]  dy_next;

    // handshake between the two register stages
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg  <= req_type;
            kind_reg <= is_button;
            code_reg <= input_code;
            cx_reg   <= cursor_x;
            cy_reg   <= cursor_y;
        end
    end

    // entry table
    assign tbl_req.fire = s1_advance;
    assign tbl_req.req  = req_reg;
    assign tbl_req.kind = kind_reg;
    assign tbl_req.code = code_reg;

    kbest_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

    // cursor sample and delta
    kbest_cursor u_cursor (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (s1_advance && (req_reg == kbest_pkg::REQ_TICK)),
        .cursor_x     (cx_reg),
        .cursor_y     (cy_reg),
        .delta_x_next (dx_next),
        .delta_y_next (dy_next)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            state_reg <= tbl_rsp.state;
            full_reg  <= tbl_rsp.full;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_state = state_reg;
    assign delta_x     = dx_reg;
    assign delta_y     = dy_reg;
    assign table_full  = full_reg;

endmodule
